// ===== design/qpc_pkg.sv =====
package qpc_pkg;

    // Default position word width (two's complement, 16 fraction bits by default).
    localparam int QPC_POS_WIDTH = 24;
    // Quaternion component width, Q1.15.
    localparam int QPC_Q_WIDTH   = 16;
    // Width of the narrow multiplier operand: holds a rounded matrix entry.
    localparam int QPC_M_WIDTH   = 20;
    // Configuration register indexes.
    localparam int QPC_CFG_IDX_WIDTH = 3;
    localparam logic [2:0] CFG_MOUNT_X  = 3'd0;
    localparam logic [2:0] CFG_MOUNT_Y  = 3'd1;
    localparam logic [2:0] CFG_MOUNT_Z  = 3'd2;
    localparam logic [2:0] CFG_MOUNT_QW = 3'd3;
    localparam logic [2:0] CFG_MOUNT_QX = 3'd4;
    localparam logic [2:0] CFG_MOUNT_QY = 3'd5;
    localparam logic [2:0] CFG_MOUNT_QZ = 3'd6;
    // Identity quaternion w component.
    localparam logic [15:0] QPC_Q_ONE = 16'h7fff;

    // Last step count of each datapath phase.
    localparam logic [4:0] PROD_LAST = 5'd8;
    localparam logic [4:0] MAT_LAST  = 5'd8;
    localparam logic [4:0] ROT_LAST  = 5'd9;
    localparam logic [4:0] HAM_LAST  = 5'd16;
    localparam logic [4:0] FIN_LAST  = 5'd3;

    typedef enum logic [2:0] {
        PH_NONE = 3'd0,
        PH_PROD = 3'd1,
        PH_MAT  = 3'd2,
        PH_ROT  = 3'd3,
        PH_HAM  = 3'd4,
        PH_FIN  = 3'd5
    } t_phase;

    typedef struct packed {
        logic       load;
        t_phase     phase;
        logic [4:0] cnt;
        logic       out_load;
    } t_qpc_cmd;

    typedef struct packed {
        logic mode;
    } t_qpc_stat;

endpackage

// ===== design/qpc_in_if.sv =====
interface qpc_in_if #(parameter int POS_WIDTH = qpc_pkg::QPC_POS_WIDTH);
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic signed [POS_WIDTH-1:0] pos_x;
    logic signed [POS_WIDTH-1:0] pos_y;
    logic signed [POS_WIDTH-1:0] pos_z;
    logic signed [15:0]          quat_w;
    logic signed [15:0]          quat_x;
    logic signed [15:0]          quat_y;
    logic signed [15:0]          quat_z;

    modport source (output valid, mode, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                    input ready);
    modport sink   (input valid, mode, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                    output ready);
endinterface

// ===== design/qpc_out_if.sv =====
interface qpc_out_if #(parameter int POS_WIDTH = qpc_pkg::QPC_POS_WIDTH);
    logic                        valid;
    logic                        ready;
    logic signed [POS_WIDTH-1:0] out_x;
    logic signed [POS_WIDTH-1:0] out_y;
    logic signed [POS_WIDTH-1:0] out_z;
    logic signed [15:0]          out_qw;
    logic signed [15:0]          out_qx;
    logic signed [15:0]          out_qy;
    logic signed [15:0]          out_qz;

    modport source (output valid, out_x, out_y, out_z, out_qw, out_qx, out_qy, out_qz,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_qw, out_qx, out_qy, out_qz,
                    output ready);
endinterface

// ===== design/qpc_ctrl.sv =====
module qpc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  qpc_pkg::t_qpc_stat  i_stat,
    output qpc_pkg::t_qpc_cmd   o_cmd
);
    import qpc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PROD = 7'b0000010,
        S_MAT  = 7'b0000100,
        S_ROT  = 7'b0001000,
        S_HAM  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    logic       w_out_load;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_out_load  = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt + 5'd1;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        o_cmd.load     = 1'b0;
        o_cmd.phase    = PH_NONE;
        o_cmd.cnt      = r_cnt;
        o_cmd.out_load = w_out_load;
        case (r_state)
            S_IDLE: begin
                n_cnt = 5'd0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PROD;
                end
            end
            S_PROD: begin
                o_cmd.phase = PH_PROD;
                if (r_cnt == PROD_LAST) begin
                    n_cnt   = 5'd0;
                    n_state = S_MAT;
                end
            end
            S_MAT: begin
                o_cmd.phase = PH_MAT;
                if (r_cnt == MAT_LAST) begin
                    n_cnt   = 5'd0;
                    n_state = S_ROT;
                end
            end
            S_ROT: begin
                o_cmd.phase = PH_ROT;
                if (r_cnt == ROT_LAST) begin
                    n_cnt   = 5'd0;
                    n_state = i_stat.mode ? S_FIN : S_HAM;
                end
            end
            S_HAM: begin
                o_cmd.phase = PH_HAM;
                if (r_cnt == HAM_LAST) begin
                    n_cnt   = 5'd0;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.phase = PH_FIN;
                if (r_cnt == FIN_LAST) begin
                    n_cnt   = 5'd0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_cnt = 5'd0;
                if (w_out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = 5'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 5'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== design/qpc_datapath.sv =====
module qpc_datapath #(
    parameter int POS_WIDTH = qpc_pkg::QPC_POS_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  qpc_pkg::t_qpc_cmd                      i_cmd,
    output qpc_pkg::t_qpc_stat                     o_stat,
    input  logic                                   i_cfg_we,
    input  logic [qpc_pkg::QPC_CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [POS_WIDTH-1:0]                   i_cfg_data,
    input  logic                                   i_mode,
    input  logic signed [POS_WIDTH-1:0]            i_pos [3],
    input  logic signed [15:0]                     i_quat [4],
    output logic signed [POS_WIDTH-1:0]            o_pos [3],
    output logic signed [15:0]                     o_quat [4]
);
    import qpc_pkg::*;

    localparam int MA    = QPC_M_WIDTH;
    localparam int PRODW = MA + POS_WIDTH;
    localparam int ACCW  = PRODW + 2;
    localparam int TW    = 35;
    localparam logic signed [ACCW-1:0] POS_MAX =
        {{(ACCW-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
    localparam logic signed [ACCW-1:0] POS_MIN = ~POS_MAX;
    localparam logic signed [TW-1:0] Q_MAX = TW'(32767);
    localparam logic signed [TW-1:0] Q_MIN = ~Q_MAX;
    localparam logic signed [33:0] M_ONE = 34'sd1 <<< 30;

    logic                        r_mode;
    logic signed [POS_WIDTH-1:0] r_pin [3];
    logic signed [15:0]          r_qin [4];
    logic signed [POS_WIDTH-1:0] r_mount_p [3];
    logic signed [15:0]          r_mount_q [4];
    logic signed [POS_WIDTH-1:0] r_cam_p [3];
    logic signed [15:0]          r_cam_q [4];
    logic signed [31:0]          r_qp [9];
    logic signed [MA-1:0]        r_m [9];
    logic signed [PRODW-1:0]     r_prod;
    logic signed [ACCW-1:0]      r_acc [3];
    logic signed [TW-1:0]        r_t [4];
    logic signed [POS_WIDTH-1:0] r_res [3];
    logic signed [POS_WIDTH-1:0] r_out_p [3];
    logic signed [15:0]          r_out_q [4];

    logic signed [MA-1:0]        w_mul_a;
    logic signed [POS_WIDTH-1:0] w_mul_b;
    logic signed [PRODW-1:0]     w_prod;
    logic signed [15:0]          w_rq [4];
    logic signed [POS_WIDTH-1:0] w_vec [3];
    logic signed [POS_WIDTH-1:0] w_base [3];
    logic signed [33:0]          w_entry;
    logic signed [33:0]          w_entry_rnd;
    logic [3:0]                  w_k;
    logic [3:0]                  w_rc_mul;
    logic [3:0]                  w_rc_acc;
    logic [3:0]                  w_hk;
    logic                        w_neg;
    logic [1:0]                  w_fi;
    logic signed [ACCW-1:0]      w_row_rnd;
    logic signed [ACCW-1:0]      w_row_sum;
    logic signed [POS_WIDTH-1:0] w_row_sat;
    logic signed [TW-1:0]        w_q_rnd;
    logic signed [15:0]          w_q_sat;
    logic signed [ACCW-1:0]      w_prod_ext;

    // Maps a matrix step 0..8 to {row, column}.
    function automatic logic [3:0] row_col(input logic [3:0] k);
        logic [3:0] rc;
        case (k)
            4'd0: rc = {2'd0, 2'd0};
            4'd1: rc = {2'd0, 2'd1};
            4'd2: rc = {2'd0, 2'd2};
            4'd3: rc = {2'd1, 2'd0};
            4'd4: rc = {2'd1, 2'd1};
            4'd5: rc = {2'd1, 2'd2};
            4'd6: rc = {2'd2, 2'd0};
            4'd7: rc = {2'd2, 2'd1};
            4'd8: rc = {2'd2, 2'd2};
            default: rc = {2'd0, 2'd0};
        endcase
        return rc;
    endfunction

    function automatic logic signed [33:0] qp_ext(input logic signed [31:0] v);
        return {{2{v[31]}}, v};
    endfunction

    assign o_stat.mode = r_mode;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_rq[i] = r_mode ? r_cam_q[i] : r_qin[i];
        end
        for (int i = 0; i < 3; i++) begin
            w_vec[i]  = r_mode ? r_pin[i] : r_mount_p[i];
            w_base[i] = r_mode ? r_cam_p[i] : r_pin[i];
        end
    end

    // Multiplier operand selection; products xx yy zz xy xz yz wx wy wz first.
    assign w_k      = i_cmd.cnt[3:0];
    assign w_rc_mul = row_col(w_k);
    assign w_rc_acc = row_col(w_k - 4'd1);
    assign w_hk     = w_k - 4'd1;

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_cmd.phase)
            PH_PROD: begin
                case (w_k)
                    4'd0: begin w_mul_a = MA'(w_rq[1]); w_mul_b = POS_WIDTH'(w_rq[1]); end
                    4'd1: begin w_mul_a = MA'(w_rq[2]); w_mul_b = POS_WIDTH'(w_rq[2]); end
                    4'd2: begin w_mul_a = MA'(w_rq[3]); w_mul_b = POS_WIDTH'(w_rq[3]); end
                    4'd3: begin w_mul_a = MA'(w_rq[1]); w_mul_b = POS_WIDTH'(w_rq[2]); end
                    4'd4: begin w_mul_a = MA'(w_rq[1]); w_mul_b = POS_WIDTH'(w_rq[3]); end
                    4'd5: begin w_mul_a = MA'(w_rq[2]); w_mul_b = POS_WIDTH'(w_rq[3]); end
                    4'd6: begin w_mul_a = MA'(w_rq[0]); w_mul_b = POS_WIDTH'(w_rq[1]); end
                    4'd7: begin w_mul_a = MA'(w_rq[0]); w_mul_b = POS_WIDTH'(w_rq[2]); end
                    4'd8: begin w_mul_a = MA'(w_rq[0]); w_mul_b = POS_WIDTH'(w_rq[3]); end
                    default: begin w_mul_a = '0; w_mul_b = '0; end
                endcase
            end
            PH_ROT: begin
                if (i_cmd.cnt < ROT_LAST) begin
                    w_mul_a = r_m[w_k];
                    w_mul_b = w_vec[w_rc_mul[1:0]];
                end
            end
            PH_HAM: begin
                if (i_cmd.cnt < HAM_LAST) begin
                    w_mul_a = MA'(r_qin[w_k[1:0]]);
                    w_mul_b = POS_WIDTH'(r_mount_q[w_k[1:0] ^ w_k[3:2]]);
                end
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod     = w_mul_a * w_mul_b;
    assign w_prod_ext = ACCW'(r_prod);

    // Rotation matrix entry from the stored component products.
    always_comb begin
        case (w_k)
            4'd0: w_entry = M_ONE - ((qp_ext(r_qp[1]) + qp_ext(r_qp[2])) <<< 1);
            4'd1: w_entry = (qp_ext(r_qp[3]) - qp_ext(r_qp[8])) <<< 1;
            4'd2: w_entry = (qp_ext(r_qp[4]) + qp_ext(r_qp[7])) <<< 1;
            4'd3: w_entry = (qp_ext(r_qp[3]) + qp_ext(r_qp[8])) <<< 1;
            4'd4: w_entry = M_ONE - ((qp_ext(r_qp[0]) + qp_ext(r_qp[2])) <<< 1);
            4'd5: w_entry = (qp_ext(r_qp[5]) - qp_ext(r_qp[6])) <<< 1;
            4'd6: w_entry = (qp_ext(r_qp[4]) - qp_ext(r_qp[7])) <<< 1;
            4'd7: w_entry = (qp_ext(r_qp[5]) + qp_ext(r_qp[6])) <<< 1;
            4'd8: w_entry = M_ONE - ((qp_ext(r_qp[0]) + qp_ext(r_qp[1])) <<< 1);
            default: w_entry = '0;
        endcase
        w_entry_rnd = (w_entry + 34'sd16384) >>> 15;
    end

    // Sign of each Hamilton product term, taken in (output, left component) order.
    always_comb begin
        case (w_hk)
            4'd1, 4'd2, 4'd3, 4'd7, 4'd9, 4'd14: w_neg = 1'b1;
            default:                             w_neg = 1'b0;
        endcase
    end

    // Final rounding and saturation for one row and one quaternion component.
    assign w_fi = i_cmd.cnt[1:0];
    always_comb begin
        w_row_rnd = (r_acc[(w_fi == 2'd3) ? 2'd0 : w_fi] + ACCW'(16384)) >>> 15;
        w_row_sum = ACCW'(w_base[(w_fi == 2'd3) ? 2'd0 : w_fi]) + w_row_rnd;
        if (w_row_sum > POS_MAX) begin
            w_row_sat = POS_MAX[POS_WIDTH-1:0];
        end else if (w_row_sum < POS_MIN) begin
            w_row_sat = POS_MIN[POS_WIDTH-1:0];
        end else begin
            w_row_sat = w_row_sum[POS_WIDTH-1:0];
        end
        w_q_rnd = (r_t[w_fi] + TW'(16384)) >>> 15;
        if (w_q_rnd > Q_MAX) begin
            w_q_sat = 16'sh7fff;
        end else if (w_q_rnd < Q_MIN) begin
            w_q_sat = -16'sh8000;
        end else begin
            w_q_sat = w_q_rnd[15:0];
        end
    end

    // Mount pose and camera pose registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_mount_p[i] <= '0;
                r_cam_p[i]   <= '0;
            end
            r_mount_q[0] <= QPC_Q_ONE;
            r_cam_q[0]   <= QPC_Q_ONE;
            for (int i = 1; i < 4; i++) begin
                r_mount_q[i] <= '0;
                r_cam_q[i]   <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MOUNT_X:  r_mount_p[0] <= i_cfg_data;
                    CFG_MOUNT_Y:  r_mount_p[1] <= i_cfg_data;
                    CFG_MOUNT_Z:  r_mount_p[2] <= i_cfg_data;
                    CFG_MOUNT_QW: r_mount_q[0] <= i_cfg_data[15:0];
                    CFG_MOUNT_QX: r_mount_q[1] <= i_cfg_data[15:0];
                    CFG_MOUNT_QY: r_mount_q[2] <= i_cfg_data[15:0];
                    CFG_MOUNT_QZ: r_mount_q[3] <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.phase == PH_FIN && !r_mode) begin
                if (w_fi != 2'd3) begin
                    r_cam_p[w_fi] <= w_row_sat;
                end
                r_cam_q[w_fi] <= w_q_sat;
            end
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_pin  <= i_pos;
            r_qin  <= i_quat;
        end
        case (i_cmd.phase)
            PH_PROD: r_qp[w_k] <= w_prod[31:0];
            PH_MAT:  r_m[w_k]  <= w_entry_rnd[MA-1:0];
            PH_ROT: begin
                if (i_cmd.cnt != 5'd0) begin
                    if (w_rc_acc[1:0] == 2'd0) begin
                        r_acc[w_rc_acc[3:2]] <= w_prod_ext;
                    end else begin
                        r_acc[w_rc_acc[3:2]] <= r_acc[w_rc_acc[3:2]] + w_prod_ext;
                    end
                end
            end
            PH_HAM: begin
                if (i_cmd.cnt != 5'd0) begin
                    if (w_hk[1:0] == 2'd0) begin
                        r_t[w_hk[3:2]] <= r_prod[TW-1:0];
                    end else if (w_neg) begin
                        r_t[w_hk[3:2]] <= r_t[w_hk[3:2]] - r_prod[TW-1:0];
                    end else begin
                        r_t[w_hk[3:2]] <= r_t[w_hk[3:2]] + r_prod[TW-1:0];
                    end
                end
            end
            PH_FIN: begin
                if (w_fi != 2'd3) begin
                    r_res[w_fi] <= w_row_sat;
                end
            end
            default: ;
        endcase
        if (i_cmd.out_load) begin
            r_out_p <= r_res;
            r_out_q <= r_cam_q;
        end
    end

    assign o_pos  = r_out_p;
    assign o_quat = r_out_q;

endmodule

// ===== design/quaternion_pose_compose_unit.sv =====
// Channel   Direction  Content
// i_in      in         mode, pos_x/y/z (POS_WIDTH), quat_w/x/y/z (Q1.15)
// o_out     out        out_x/y/z (POS_WIDTH), out_qw/qx/qy/qz (Q1.15)
// i_cfg_*   in         register index and write data, written when i_cfg_we is high
//
// Each item runs in turn through the component products, the matrix entries, the
// matrix products, in mode 0 the Hamilton products, and the rounding, and is then
// loaded into the output register. All products go through the single shared
// multiplier: 9 component products, 9 matrix products and, in mode 0, 16 Hamilton
// products, with a drain step after each run of matrix or Hamilton products.
// Reset is synchronous and active low; it restores the identity mount and camera
// poses. A stalled result holds in the output register while the next item runs;
// that item then waits for the output register to free, with the input not ready.
module quaternion_pose_compose_unit #(
    parameter int POS_WIDTH = qpc_pkg::QPC_POS_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    qpc_in_if.sink                                 i_in,
    qpc_out_if.source                              o_out,
    input  logic                                   i_cfg_we,
    input  logic [qpc_pkg::QPC_CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [POS_WIDTH-1:0]                   i_cfg_data
);
    import qpc_pkg::*;

    t_qpc_cmd                    w_cmd;
    t_qpc_stat                   w_stat;
    logic signed [POS_WIDTH-1:0] w_in_pos [3];
    logic signed [15:0]          w_in_quat [4];
    logic signed [POS_WIDTH-1:0] w_out_pos [3];
    logic signed [15:0]          w_out_quat [4];

    assign w_in_pos[0]  = i_in.pos_x;
    assign w_in_pos[1]  = i_in.pos_y;
    assign w_in_pos[2]  = i_in.pos_z;
    assign w_in_quat[0] = i_in.quat_w;
    assign w_in_quat[1] = i_in.quat_x;
    assign w_in_quat[2] = i_in.quat_y;
    assign w_in_quat[3] = i_in.quat_z;

    // The controller sequences the phases and owns both handshakes.
    qpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the mount and camera poses and the shared multiplier.
    qpc_datapath #(.POS_WIDTH(POS_WIDTH)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_mode     (i_in.mode),
        .i_pos      (w_in_pos),
        .i_quat     (w_in_quat),
        .o_pos      (w_out_pos),
        .o_quat     (w_out_quat)
    );

    assign o_out.out_x  = w_out_pos[0];
    assign o_out.out_y  = w_out_pos[1];
    assign o_out.out_z  = w_out_pos[2];
    assign o_out.out_qw = w_out_quat[0];
    assign o_out.out_qx = w_out_quat[1];
    assign o_out.out_qy = w_out_quat[2];
    assign o_out.out_qz = w_out_quat[3];

endmodule

// ===== design/qpc_checker.sv =====
module qpc_port_checker #(
    parameter int POS_WIDTH = qpc_pkg::QPC_POS_WIDTH
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [POS_WIDTH-1:0] i_out_x,
    input logic [15:0]          i_out_qw
);

    // A stalled result keeps its valid and its data.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_x) && $stable(i_out_qw)))
        else $error("stalled result changed");

    // One item at a time: no transfer in right after a transfer in.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready while an item is in work");

    // A new result appears only at the end of work on an item.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared without work");

    // Reset leaves the block empty and ready.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("block not idle after reset");

endmodule

bind quaternion_pose_compose_unit qpc_port_checker #(.POS_WIDTH(POS_WIDTH)) u_qpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_x     (o_out.out_x),
    .i_out_qw    (o_out.out_qw)
);

// ===== sim/qpc_checker.sv =====
`timescale 1ns / 1ps

module qpc_checker #(
    parameter int POS_WIDTH = qpc_pkg::QPC_POS_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [qpc_pkg::QPC_CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [POS_WIDTH-1:0]                  i_cfg_data,
    qpc_in_if                                     mon_in,
    qpc_out_if                                    mon_out,
    output int                                    o_mismatches,
    output int                                    o_pending,
    output int                                    o_checked,
    output int                                    o_mode1_seen
);
    import qpc_pkg::*;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] x;
        logic signed [POS_WIDTH-1:0] y;
        logic signed [POS_WIDTH-1:0] z;
        logic signed [15:0]          qw;
        logic signed [15:0]          qx;
        logic signed [15:0]          qy;
        logic signed [15:0]          qz;
    } t_pose;

    longint mount_pos[3];
    longint mount_rot[4];
    longint cam_pos[3];
    longint cam_rot[4];
    t_pose  pose_queue[$];

    function automatic longint round15(longint v);
        return (v + 64'sd16384) >>> 15;
    endfunction

    function automatic longint clamp(longint v, int w);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // base + R(q) * p, with each matrix entry rounded to Q1.15 first.
    task automatic rotate_offset(input longint q[4], input longint p[3],
                                 input longint base[3], output longint res[3]);
        longint m[9];
        longint acc;
        longint w, x, y, z;
        w = q[0]; x = q[1]; y = q[2]; z = q[3];
        m[0] = (64'sd1 <<< 30) - 2 * (y * y + z * z);
        m[1] = 2 * (x * y - w * z);
        m[2] = 2 * (x * z + w * y);
        m[3] = 2 * (x * y + w * z);
        m[4] = (64'sd1 <<< 30) - 2 * (x * x + z * z);
        m[5] = 2 * (y * z - w * x);
        m[6] = 2 * (x * z - w * y);
        m[7] = 2 * (y * z + w * x);
        m[8] = (64'sd1 <<< 30) - 2 * (x * x + y * y);
        for (int i = 0; i < 9; i++) m[i] = round15(m[i]);
        for (int i = 0; i < 3; i++) begin
            acc = m[3 * i] * p[0] + m[3 * i + 1] * p[1] + m[3 * i + 2] * p[2];
            res[i] = clamp(base[i] + round15(acc), POS_WIDTH);
        end
    endtask

    task automatic hamilton(input longint a[4], input longint b[4], output longint r[4]);
        longint t[4];
        t[0] = a[0] * b[0] - a[1] * b[1] - a[2] * b[2] - a[3] * b[3];
        t[1] = a[0] * b[1] + a[1] * b[0] + a[2] * b[3] - a[3] * b[2];
        t[2] = a[0] * b[2] - a[1] * b[3] + a[2] * b[0] + a[3] * b[1];
        t[3] = a[0] * b[3] + a[1] * b[2] - a[2] * b[1] + a[3] * b[0];
        for (int i = 0; i < 4; i++) r[i] = clamp(round15(t[i]), 16);
    endtask

    task automatic predict_pose();
        longint p[3];
        longint q[4];
        longint res[3];
        longint nq[4];
        t_pose  e;
        p[0] = longint'(mon_in.pos_x);
        p[1] = longint'(mon_in.pos_y);
        p[2] = longint'(mon_in.pos_z);
        if (!mon_in.mode) begin
            q[0] = longint'(mon_in.quat_w);
            q[1] = longint'(mon_in.quat_x);
            q[2] = longint'(mon_in.quat_y);
            q[3] = longint'(mon_in.quat_z);
            rotate_offset(q, mount_pos, p, res);
            hamilton(q, mount_rot, nq);
            cam_pos = res;
            cam_rot = nq;
        end else begin
            rotate_offset(cam_rot, p, cam_pos, res);
            o_mode1_seen++;
        end
        e.x  = res[0][POS_WIDTH-1:0];
        e.y  = res[1][POS_WIDTH-1:0];
        e.z  = res[2][POS_WIDTH-1:0];
        e.qw = cam_rot[0][15:0];
        e.qx = cam_rot[1][15:0];
        e.qy = cam_rot[2][15:0];
        e.qz = cam_rot[3][15:0];
        pose_queue.push_back(e);
    endtask

    task automatic check_pose();
        t_pose  e;
        longint ev[7];
        longint av[7];
        string  names[7];
        bit     bad;
        names = '{"out_x", "out_y", "out_z", "out_qw", "out_qx", "out_qy", "out_qz"};
        if (pose_queue.size() == 0) begin
            o_mismatches++;
            if (o_mismatches <= 10) $display("ERROR: unexpected result at %0t", $realtime);
            return;
        end
        e = pose_queue.pop_front();
        ev = '{e.x, e.y, e.z, e.qw, e.qx, e.qy, e.qz};
        av = '{mon_out.out_x, mon_out.out_y, mon_out.out_z, mon_out.out_qw,
               mon_out.out_qx, mon_out.out_qy, mon_out.out_qz};
        bad = 0;
        for (int i = 0; i < 7; i++) begin
            if (ev[i] != av[i]) begin
                if (!bad) o_mismatches++;
                bad = 1;
                if (o_mismatches <= 10)
                    $display("ERROR: result %0d %s expected %0d got %0d",
                             o_checked, names[i], ev[i], av[i]);
            end
        end
        o_checked++;
    endtask

    initial begin
        o_mismatches = 0;
        o_checked = 0;
        o_mode1_seen = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mount_pos = '{0, 0, 0};
            cam_pos   = '{0, 0, 0};
            mount_rot = '{32767, 0, 0, 0};
            cam_rot   = '{32767, 0, 0, 0};
            pose_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MOUNT_X:  mount_pos[0] = longint'($signed(i_cfg_data));
                    CFG_MOUNT_Y:  mount_pos[1] = longint'($signed(i_cfg_data));
                    CFG_MOUNT_Z:  mount_pos[2] = longint'($signed(i_cfg_data));
                    CFG_MOUNT_QW: mount_rot[0] = longint'($signed(i_cfg_data[15:0]));
                    CFG_MOUNT_QX: mount_rot[1] = longint'($signed(i_cfg_data[15:0]));
                    CFG_MOUNT_QY: mount_rot[2] = longint'($signed(i_cfg_data[15:0]));
                    CFG_MOUNT_QZ: mount_rot[3] = longint'($signed(i_cfg_data[15:0]));
                    default: ;
                endcase
            end
            if (mon_out.valid && mon_out.ready) check_pose();
            if (mon_in.valid && mon_in.ready) predict_pose();
        end
        o_pending = pose_queue.size();
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import qpc_pkg::*;

    localparam int PW = QPC_POS_WIDTH;
    // Cycles without any transfer before the run is declared hung. It lies above
    // the long receiver hold-off and the work time of one item.
    localparam int STALL_LIMIT = 5000;
    localparam int ITEMS_PER_PHASE = 300;

    logic          i_clk;
    logic          i_rst_n;
    logic          cfg_we;
    logic [2:0]    cfg_idx;
    logic [PW-1:0] cfg_data;

    int  mismatches;
    int  pending;
    int  checked;
    int  mode1_seen;
    int  sent;
    bit  gaps_on;      // When clear, both sides run without idle cycles.
    bit  hold_req;     // Asks the receiver for one long hold-off.
    int  quiet_cycles;

    qpc_in_if  #(.POS_WIDTH(PW)) in_ch ();
    qpc_out_if #(.POS_WIDTH(PW)) out_ch ();

    quaternion_pose_compose_unit #(.POS_WIDTH(PW)) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .o_out     (out_ch),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    qpc_checker #(.POS_WIDTH(PW)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .mon_in      (in_ch),
        .mon_out     (out_ch),
        .o_mismatches(mismatches),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_mode1_seen(mode1_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // The watchdog restarts its count on every transfer on either channel.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired after %0d quiet cycles", STALL_LIMIT);
            $display("quaternion_pose_compose_unit test failed");
            $finish;
        end
    end

    function automatic int draw_gap();
        return gaps_on ? $urandom_range(0, 18) : 0;
    endfunction

    // The receiver draws a wait before each result. Once per run it honors
    // a request to hold off for a long stretch so that the block backs up.
    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ch.ready = 1'b0;
                repeat (400) @(negedge i_clk);
                hold_req = 1'b0;
            end
            out_ch.ready = 1'b0;
            repeat (draw_gap()) @(negedge i_clk);
            out_ch.ready = 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [PW-1:0] val);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_mount(input logic [PW-1:0] x, input logic [PW-1:0] y,
                              input logic [PW-1:0] z, input logic [15:0] qw,
                              input logic [15:0] qx, input logic [15:0] qy,
                              input logic [15:0] qz);
        write_reg(CFG_MOUNT_X, x);
        write_reg(CFG_MOUNT_Y, y);
        write_reg(CFG_MOUNT_Z, z);
        write_reg(CFG_MOUNT_QW, {{(PW-16){qw[15]}}, qw});
        write_reg(CFG_MOUNT_QX, {{(PW-16){qx[15]}}, qx});
        write_reg(CFG_MOUNT_QY, {{(PW-16){qy[15]}}, qy});
        write_reg(CFG_MOUNT_QZ, {{(PW-16){qz[15]}}, qz});
    endtask

    // Waits for every outstanding result, then lets the pipeline drain fully.
    task automatic settle();
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    // Offers one item after a drawn gap and holds it until the transfer.
    task automatic send_item(input logic m, input logic [PW-1:0] px, input logic [PW-1:0] py,
                             input logic [PW-1:0] pz, input logic [15:0] qw,
                             input logic [15:0] qx, input logic [15:0] qy,
                             input logic [15:0] qz);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.mode   = m;
        in_ch.pos_x  = px;
        in_ch.pos_y  = py;
        in_ch.pos_z  = pz;
        in_ch.quat_w = qw;
        in_ch.quat_x = qx;
        in_ch.quat_y = qy;
        in_ch.quat_z = qz;
        in_ch.valid  = 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    function automatic logic [PW-1:0] rand_pos();
        logic [PW-1:0] v;
        v = PW'($urandom);
        case ($urandom_range(0, 9))
            0: v = {1'b0, {(PW-1){1'b1}}};
            1: v = {1'b1, {(PW-1){1'b0}}};
            2, 3, 4: v = $signed(v) >>> $urandom_range(4, 12);
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] rand_comp();
        logic [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(0, 7))
            0: v = 16'h7fff;
            1: v = 16'h8000;
            2: v = 16'h8001;
            3, 4: v = $signed(v) >>> $urandom_range(1, 6);
            default: ;
        endcase
        return v;
    endfunction

    // Mostly near-unit rotations (one dominant axis), the rest arbitrary.
    task automatic random_item();
        logic [15:0] q[4];
        int          axis;
        for (int i = 0; i < 4; i++) q[i] = rand_comp();
        if ($urandom_range(0, 2) != 0) begin
            axis = $urandom_range(0, 3);
            for (int i = 0; i < 4; i++) q[i] = $signed(q[i]) >>> 5;
            q[axis] = $urandom_range(0, 1) ? 16'sd32000 : -16'sd32000;
        end
        send_item(1'($urandom_range(0, 1)), rand_pos(), rand_pos(), rand_pos(),
                  q[0], q[1], q[2], q[3]);
    endtask

    task automatic random_phase(input int n, input bit pressure);
        for (int k = 0; k < n; k++) begin
            if (k % 60 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            if (pressure && k == 20) begin
                gaps_on  = 1'b0;
                hold_req = 1'b1;
            end
            random_item();
        end
        in_ch.valid = 1'b0;
        settle();
    endtask

    localparam logic [PW-1:0] PMAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic [PW-1:0] PMIN = {1'b1, {(PW-1){1'b0}}};

    initial begin
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_MOUNT_X;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.mode   = 1'b0;
        in_ch.pos_x  = '0;
        in_ch.pos_y  = '0;
        in_ch.pos_z  = '0;
        in_ch.quat_w = '0;
        in_ch.quat_x = '0;
        in_ch.quat_y = '0;
        in_ch.quat_z = '0;
        gaps_on      = 1'b1;
        hold_req     = 1'b0;
        sent         = 0;
        quiet_cycles = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: a point transform before any pose was composed uses the
        // reset pose, then identity, extreme and non-unit quaternions with
        // positions at both ends of their range.
        send_item(1'b1, 24'h010000, PMIN, PMAX, 16'h1234, 16'h8000, 16'h7fff, 16'h0000);
        send_item(1'b0, 24'h000000, 24'h000000, 24'h000000, QPC_Q_ONE, 0, 0, 0);
        send_item(1'b1, PMAX, PMAX, PMAX, 0, 0, 0, 0);
        send_item(1'b1, PMIN, PMIN, PMIN, 0, 0, 0, 0);
        in_ch.valid = 1'b0;
        settle();
        load_mount(24'h020000, 24'hfe8000, 24'h004000, 16'h5a82, 16'h0000, 16'h5a82, 16'h0000);
        send_item(1'b0, 24'h100000, 24'hf00000, 24'h000123,
                  16'h7fff, 16'h0000, 16'h0000, 16'h0000);
        send_item(1'b1, 24'h010000, 24'h020000, 24'h030000, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_item(1'b0, PMAX, PMAX, PMAX, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_item(1'b1, PMAX, PMIN, PMAX, 0, 0, 0, 0);
        send_item(1'b0, PMIN, PMIN, PMIN, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_item(1'b1, PMIN, PMAX, PMIN, 0, 0, 0, 0);
        send_item(1'b0, 0, 0, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(1'b1, 24'h7f0000, 24'h810000, 24'h000001, 0, 0, 0, 0);
        send_item(1'b0, 24'h000001, 24'hffffff, 24'h000000,
                  16'h0000, 16'h7fff, 16'h0000, 16'h0000);
        send_item(1'b1, 24'h000001, 24'hffffff, 24'h555555, 0, 0, 0, 0);
        send_item(1'b0, 24'h123456, 24'h654321, 24'habcdef,
                  16'h0000, 16'h0000, 16'h8000, 16'h0000);
        send_item(1'b1, 24'h000000, 24'h000000, 24'h000000, 0, 0, 0, 0);
        in_ch.valid = 1'b0;
        settle();

        // Register settings: the mount loaded above, both extremes, zero,
        // random values, and a write to an index past the register list.
        random_phase(ITEMS_PER_PHASE, 1'b1);
        load_mount(PMAX, PMAX, PMAX, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        random_phase(ITEMS_PER_PHASE, 1'b0);
        load_mount(PMIN, PMIN, PMIN, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        random_phase(ITEMS_PER_PHASE, 1'b0);
        load_mount(0, 0, 0, 0, 0, 0, 0);
        write_reg(3'd7, PW'($urandom));
        random_phase(ITEMS_PER_PHASE, 1'b0);
        for (int r = 0; r < 2; r++) begin
            load_mount(rand_pos(), rand_pos(), rand_pos(),
                       rand_comp(), rand_comp(), rand_comp(), rand_comp());
            random_phase(ITEMS_PER_PHASE, 1'b0);
        end

        $display("Sent %0d poses and points over six mount settings, %0d of them point transforms.",
                 sent, mode1_seen);
        $display("Checked %0d results, %0d mismatching, including a 400-cycle output stall.",
                 checked, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("quaternion_pose_compose_unit test passed");
        else
            $display("quaternion_pose_compose_unit test failed");
        $finish;
    end

endmodule
